@@ design/isfc_pkg.sv @@
// Package: payload structs, session modes, frame types and event codes.
package isfc_pkg;

  // Bound on a transmit request, in frames; the 10-bit frame_total tops out at 1023.
  localparam int unsigned MaxFrames = 1024;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RX   = 2'd1;
  localparam logic [1:0] MODE_TX   = 2'd2;

  localparam logic [1:0] FT_SINGLE = 2'd0;
  localparam logic [1:0] FT_FIRST  = 2'd1;
  localparam logic [1:0] FT_CONSEC = 2'd2;
  localparam logic [1:0] FT_FLOW   = 2'd3;

  localparam logic [1:0] FS_WAIT     = 2'd1;
  localparam logic [1:0] FS_OVERFLOW = 2'd2;

  localparam logic       CMD_FRAME   = 1'b0;
  localparam logic       CMD_REQUEST = 1'b1;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_RX_DONE = 2'd1;
  localparam logic [1:0] EV_TX_DONE = 2'd2;
  localparam logic [1:0] EV_ERROR   = 2'd3;

  typedef struct packed {
    logic       command;
    logic [1:0] frame_type;
    logic [3:0] seq_num;
    logic [11:0] msg_len;
    logic [1:0] fc_status;
    logic [7:0] fc_blk_frames;
    logic [7:0] fc_sep_time;
    logic [9:0] frame_total;
  } in_t;

  typedef struct packed {
    logic       send_fc;
    logic [9:0] send_start;
    logic [9:0] send_count;
    logic [7:0] send_gap;
    logic [1:0] event_res;
    logic       abandoned;
  } out_t;

endpackage

@@ design/isotp_session_flow_control.sv @@
// ISO-TP session flow control: one session, idle / receiving / transmitting.
//
// One frame or transmit request is taken per clock while in_stall_o is low;
// its result is decided in the same cycle from the session registers and is
// registered in the output register, or in the skid register while the output
// is held; session state is updated on that same edge. A two-entry output
// buffer (output register plus skid register) lets an input transaction complete
// while a result still waits; in_stall_o rises only once both entries hold results.
module isotp_session_flow_control (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  isfc_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output isfc_pkg::out_t    out_data_o
);

  logic [1:0]  mode_q, mode_d;
  logic [3:0]  rx_seq_q, rx_seq_d;
  logic [11:0] rx_length_q, rx_length_d;
  logic [9:0]  rx_count_q, rx_count_d;
  logic [9:0]  tx_total_q, tx_total_d;
  logic [9:0]  tx_next_q, tx_next_d;

  isfc_pkg::out_t res;
  isfc_pkg::out_t main_q, main_d, skid_q, skid_d;
  logic main_valid_q, main_valid_d, skid_valid_q, skid_valid_d;

  logic accept, main_free;

  // receive datapath
  logic [3:0]  seq_inc;
  logic [9:0]  cnt_inc;
  logic [13:0] rx_covered;
  // transmit datapath
  logic [9:0]  remain, n_send, next_sum;

  assign accept    = in_valid_i && !skid_valid_q;
  assign main_free = !main_valid_q || !out_stall_i;

  assign seq_inc    = rx_seq_q + 4'd1;
  assign cnt_inc    = (rx_count_q == 10'h3ff) ? rx_count_q : rx_count_q + 10'd1;
  assign rx_covered = ({1'b0, cnt_inc, 3'b000} - {4'b0000, cnt_inc}) + 14'd6;

  assign remain   = (tx_next_q < tx_total_q) ? (tx_total_q - tx_next_q) : 10'd0;
  assign n_send   = (in_data_i.fc_blk_frames == 8'd0 ||
                     {2'b00, in_data_i.fc_blk_frames} > remain)
                    ? remain : {2'b00, in_data_i.fc_blk_frames};
  assign next_sum = tx_next_q + n_send;

  always_comb begin
    mode_d      = mode_q;
    rx_seq_d    = rx_seq_q;
    rx_length_d = rx_length_q;
    rx_count_d  = rx_count_q;
    tx_total_d  = tx_total_q;
    tx_next_d   = tx_next_q;
    res         = '0;

    if (in_data_i.command == isfc_pkg::CMD_REQUEST) begin
      res.abandoned = (mode_q == isfc_pkg::MODE_RX) || (mode_q == isfc_pkg::MODE_TX);
      mode_d = isfc_pkg::MODE_IDLE;
      if (in_data_i.frame_total == 10'd0 ||
          32'(in_data_i.frame_total) > isfc_pkg::MaxFrames) begin
        res.event_res = isfc_pkg::EV_ERROR;
      end else if (in_data_i.frame_type == isfc_pkg::FT_SINGLE) begin
        res.send_count = 10'd1;
        res.event_res  = isfc_pkg::EV_TX_DONE;
      end else if (in_data_i.frame_type == isfc_pkg::FT_FIRST) begin
        res.send_count = 10'd1;
        tx_total_d     = in_data_i.frame_total;
        tx_next_d      = 10'd1;
        mode_d         = isfc_pkg::MODE_TX;
      end else begin
        res.event_res = isfc_pkg::EV_ERROR;
      end
    end else if (mode_q == isfc_pkg::MODE_RX) begin
      if (in_data_i.frame_type == isfc_pkg::FT_CONSEC) begin
        rx_seq_d   = seq_inc;
        rx_count_d = cnt_inc;
        if (seq_inc != in_data_i.seq_num) begin
          res.event_res = isfc_pkg::EV_ERROR;
          mode_d        = isfc_pkg::MODE_IDLE;
        end else if (rx_covered >= {2'b00, rx_length_q}) begin
          res.event_res = isfc_pkg::EV_RX_DONE;
          mode_d        = isfc_pkg::MODE_IDLE;
        end
      end else begin
        res.event_res = isfc_pkg::EV_ERROR;
        mode_d        = isfc_pkg::MODE_IDLE;
      end
    end else if (mode_q == isfc_pkg::MODE_TX) begin
      if (in_data_i.frame_type == isfc_pkg::FT_FLOW) begin
        if (in_data_i.fc_status == isfc_pkg::FS_WAIT) begin
          // wait: hold the session
        end else if (in_data_i.fc_status == isfc_pkg::FS_OVERFLOW) begin
          res.event_res = isfc_pkg::EV_ERROR;
          mode_d        = isfc_pkg::MODE_IDLE;
        end else begin
          if (n_send != 10'd0) begin
            res.send_start = tx_next_q;
            res.send_count = n_send;
            res.send_gap   = in_data_i.fc_sep_time;
          end
          tx_next_d = next_sum;
          if (next_sum >= tx_total_q) begin
            res.event_res = isfc_pkg::EV_TX_DONE;
            mode_d        = isfc_pkg::MODE_IDLE;
          end
        end
      end
    end else begin
      // idle, and the unused mode code
      mode_d = isfc_pkg::MODE_IDLE;
      if (in_data_i.frame_type == isfc_pkg::FT_SINGLE) begin
        res.event_res = isfc_pkg::EV_RX_DONE;
      end else if (in_data_i.frame_type == isfc_pkg::FT_FIRST) begin
        rx_length_d = in_data_i.msg_len;
        rx_seq_d    = 4'd0;
        rx_count_d  = 10'd0;
        res.send_fc = 1'b1;
        mode_d      = isfc_pkg::MODE_RX;
      end else begin
        res.event_res = isfc_pkg::EV_ERROR;
      end
    end
  end

  // output buffer: skid entry fills only when the output register is held
  always_comb begin
    main_d       = main_q;
    main_valid_d = main_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (main_free) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = res;
        main_valid_d = accept;
      end
    end else if (accept) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= isfc_pkg::MODE_IDLE;
      rx_seq_q     <= '0;
      rx_length_q  <= '0;
      rx_count_q   <= '0;
      tx_total_q   <= '0;
      tx_next_q    <= '0;
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q      <= mode_d;
        rx_seq_q    <= rx_seq_d;
        rx_length_q <= rx_length_d;
        rx_count_q  <= rx_count_d;
        tx_total_q  <= tx_total_d;
        tx_next_q   <= tx_next_d;
      end
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

@@ design/isfc_port_checker.sv @@
// Port checker for the ISO-TP session block, bound to its top level.
module isfc_port_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input isfc_pkg::out_t out_data_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a flow-control reply opens a receive session, never ends one
  a_fc_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.send_fc |->
      out_data_o.event_res == isfc_pkg::EV_NONE && !out_data_o.abandoned)
    else $error("flow-control reply with event or abandon");

  // no frames released means the whole send range is zero
  a_empty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.send_count == 10'd0 |->
      out_data_o.send_start == 10'd0 && out_data_o.send_gap == 8'd0)
    else $error("send range without frames");

  // input side only backs up after the output was held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without held output");

endmodule

bind isotp_session_flow_control isfc_port_checker u_isfc_port_checker (.*);
